// File: hdl/brtc_pkg.sv
// Package: shared types and constants for the BCD real-time clock registers.
`default_nettype none
package brtc_pkg;

  typedef enum logic [1:0] {
    ACT_SET_PTR = 2'd0,
    ACT_WRITE   = 2'd1,
    ACT_READ    = 2'd2,
    ACT_TICK    = 2'd3
  } action_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic    exec;
    action_t action;
    logic [7:0] data;
  } brtc_cmd_t;

  localparam logic [7:0] HALT_BIT  = 8'h80;
  localparam logic [7:0] MODE12    = 8'h40;
  localparam logic [7:0] PM_BIT    = 8'h20;
  localparam logic [7:0] HR12_MASK = 8'h1F;
  localparam logic [7:0] HR24_MASK = 8'h3F;
  localparam logic [7:0] MODE_MASK = 8'hC0;

  // Binary to BCD for values 0..99
  function automatic logic [7:0] to_bcd(input logic [6:0] v);
    logic [3:0] t;
    logic [6:0] r;
    begin
      t = 4'd0;
      r = v;
      if (r >= 7'd80) begin t = t + 4'd8; r = r - 7'd80; end
      if (r >= 7'd40) begin t = t + 4'd4; r = r - 7'd40; end
      if (r >= 7'd20) begin t = t + 4'd2; r = r - 7'd20; end
      if (r >= 7'd10) begin t = t + 4'd1; r = r - 7'd10; end
      to_bcd = {t, r[3:0]};
    end
  endfunction

  // BCD to binary, two nibbles, result up to 165
  function automatic logic [7:0] from_bcd(input logic [3:0] hi, input logic [3:0] lo);
    from_bcd = {1'b0, hi, 3'b000} + {3'b000, hi, 1'b0} + {4'h0, lo};
  endfunction

endpackage
`default_nettype wire

// File: hdl/brtc_ctrl.sv
// Controller: accepts items, issues datapath commands, strobes results.
`default_nettype none
module brtc_ctrl
  import brtc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  input  wire logic [1:0] in_action,
  input  wire logic [7:0] in_data_byte,
  output logic            busy,
  output brtc_cmd_t       cmd,
  output logic            out_valid
);

  typedef enum logic {ST_IDLE, ST_EXEC} state_t;
  state_t     state_r;
  action_t    action_r;
  logic [7:0] data_r;

  // Capture the item, hold the command in the execute state, then strobe the result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      out_valid <= 1'b0;
      action_r  <= ACT_SET_PTR;
      data_r    <= 8'd0;
    end else begin
      out_valid <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (start) begin
            state_r  <= ST_EXEC;
            action_r <= action_t'(in_action);
            data_r   <= in_data_byte;
          end
        end
        ST_EXEC: begin
          state_r   <= ST_IDLE;
          out_valid <= 1'b1;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign cmd  = '{exec: (state_r == ST_EXEC), action: action_r, data: data_r};
  assign busy = (state_r == ST_EXEC);

endmodule
`default_nettype wire

// File: hdl/brtc_dp.sv
// Datapath: register file, BCD decode, calendar counters and read port.
`default_nettype none
module brtc_dp
  import brtc_pkg::*;
#(
  parameter int REG_SPACE = 64
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire brtc_cmd_t  cmd,
  output logic [7:0]      out_read_data
);

  localparam int PW = $clog2(REG_SPACE);
  localparam int RAMD = REG_SPACE - 8;
  localparam int RW = $clog2(RAMD);

  logic [PW-1:0] ptr_r;
  logic [7:0]    tb_r [8];
  logic [7:0]    ram [RAMD];
  logic [5:0]    sec_r, min_r;
  logic [4:0]    hour_r, mday_r;
  logic [2:0]    wday_r;
  logic [3:0]    mon_r;
  logic [6:0]    year_r;

  logic          is_time;
  logic [RW-1:0] ram_addr;
  logic [PW-1:0] ptr_inc;
  logic [7:0]    b, dec, hdec, sdec;
  logic [4:0]    mlen;
  logic          c_sec, c_min, c_hour, c_day, c_mon;
  logic [5:0]    sec_t, min_t;
  logic [4:0]    hour_t, mday_t;
  logic [2:0]    wday_t;
  logic [3:0]    mon_t;
  logic [6:0]    year_t;
  logic [4:0]    h12;
  logic [7:0]    hbyte;

  // Reduce a pointer byte modulo the register space
  function automatic logic [PW-1:0] ptr_wrap(input logic [7:0] v);
    int r;
    r = int'(v);
    for (int k = 3; k >= 0; k--) begin
      if (r >= (REG_SPACE << k)) r = r - (REG_SPACE << k);
    end
    return PW'(r);
  endfunction

  assign b        = cmd.data;
  assign is_time  = (ptr_r < PW'(8));
  assign ram_addr = RW'(ptr_r - PW'(8));
  assign ptr_inc  = (ptr_r == PW'(REG_SPACE - 1)) ? '0 : ptr_r + PW'(1);
  assign dec      = from_bcd(b[7:4], b[3:0]);
  assign sdec     = from_bcd({1'b0, b[6:4]}, b[3:0]);

  // Decode the hours byte by 12/24 mode
  always_comb begin
    if (b[6]) begin
      hdec = from_bcd({3'b000, b[4]}, b[3:0]);
      if (b[5]) begin
        if (hdec < 8'd12) hdec = hdec + 8'd12;
      end else if (hdec == 8'd12) begin
        hdec = 8'd0;
      end
    end else begin
      hdec = from_bcd({2'b00, b[5:4]}, b[3:0]);
    end
  end

  // Month length with leap years
  always_comb begin
    case (mon_r)
      4'd2: mlen = (year_r[1:0] == 2'b00) ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: mlen = 5'd30;
      default: mlen = 5'd31;
    endcase
  end

  // Advance the calendar by one second
  always_comb begin
    c_sec  = (sec_r == 6'd59);
    c_min  = c_sec && (min_r == 6'd59);
    c_hour = c_min && (hour_r == 5'd23);
    c_day  = c_hour && (mday_r >= mlen);
    c_mon  = c_day && (mon_r >= 4'd12);
    sec_t  = c_sec ? 6'd0 : sec_r + 6'd1;
    min_t  = c_sec ? (c_min ? 6'd0 : min_r + 6'd1) : min_r;
    hour_t = c_min ? (c_hour ? 5'd0 : hour_r + 5'd1) : hour_r;
    wday_t = c_hour ? ((wday_r >= 3'd6) ? 3'd0 : wday_r + 3'd1) : wday_r;
    mday_t = c_hour ? (c_day ? 5'd1 : mday_r + 5'd1) : mday_r;
    mon_t  = c_day ? (c_mon ? 4'd1 : mon_r + 4'd1) : mon_r;
    year_t = c_mon ? ((year_r >= 7'd99) ? 7'd0 : year_r + 7'd1) : year_r;
    if (tb_r[2][6]) begin
      if (hour_t < 5'd12) begin
        h12   = (hour_t == 5'd0) ? 5'd12 : hour_t;
        hbyte = (tb_r[2] & MODE_MASK) | (to_bcd({2'b00, h12}) & HR12_MASK);
      end else begin
        h12   = (hour_t > 5'd12) ? hour_t - 5'd12 : hour_t;
        hbyte = (tb_r[2] & MODE_MASK) | PM_BIT | (to_bcd({2'b00, h12}) & HR12_MASK);
      end
    end else begin
      h12   = hour_t;
      hbyte = (tb_r[2] & MODE_MASK) | (to_bcd({2'b00, hour_t}) & HR24_MASK);
    end
  end

  // Update pointer, time bytes and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r <= '0;
      for (int i = 0; i < 8; i++) tb_r[i] <= 8'hFF;
      tb_r[2] <= 8'h3F;
      tb_r[7] <= 8'h00;
      sec_r <= '0; min_r <= '0; hour_r <= '0; wday_r <= '0;
      mday_r <= 5'd1; mon_r <= 4'd1; year_r <= '0;
    end else if (cmd.exec) begin
      case (cmd.action)
        ACT_SET_PTR: ptr_r <= ptr_wrap(b);
        ACT_WRITE: begin
          ptr_r <= ptr_inc;
          if (is_time) begin
            tb_r[ptr_r[2:0]] <= b;
            case (ptr_r[2:0])
              3'd0: sec_r <= (sdec > 8'd59) ? 6'd59 : sdec[5:0];
              3'd1: min_r <= (dec > 8'd59) ? 6'd59 : dec[5:0];
              3'd2: hour_r <= (hdec > 8'd23) ? 5'd23 : hdec[4:0];
              3'd3: wday_r <= (b[2:0] == 3'd7) ? 3'd0 : b[2:0];
              3'd4: mday_r <= (dec > 8'd31) ? 5'd31 : (dec == 8'd0) ? 5'd1 : dec[4:0];
              3'd5: mon_r <= (dec > 8'd12) ? 4'd12 : (dec == 8'd0) ? 4'd1 : dec[3:0];
              3'd6: year_r <= (dec > 8'd99) ? 7'd99 : dec[6:0];
              default: ;
            endcase
          end
        end
        ACT_READ: ptr_r <= ptr_inc;
        ACT_TICK: begin
          if (!tb_r[0][7]) begin
            sec_r <= sec_t; min_r <= min_t; hour_r <= hour_t; wday_r <= wday_t;
            mday_r <= mday_t; mon_r <= mon_t; year_r <= year_t;
            tb_r[0] <= to_bcd({1'b0, sec_t});
            tb_r[1] <= to_bcd({1'b0, min_t});
            tb_r[2] <= hbyte;
            tb_r[3] <= (wday_t == 3'd0) ? 8'd7 : {5'd0, wday_t};
            tb_r[4] <= to_bcd({2'b00, mday_t});
            tb_r[5] <= to_bcd({3'b000, mon_t});
            tb_r[6] <= to_bcd(year_t);
          end
        end
        default: ;
      endcase
    end
  end

  // User RAM write and registered read
  always_ff @(posedge clk) begin
    if (cmd.exec && cmd.action == ACT_WRITE && !is_time) ram[ram_addr] <= b;
  end

  logic [7:0] ram_q;
  always_ff @(posedge clk) begin
    ram_q <= ram[ram_addr];
  end

  // Drive the result byte in the strobe cycle
  logic       rd_r, rd_time_r;
  logic [7:0] rd_tb_r;
  always_ff @(posedge clk) begin
    if (!rst_n) rd_r <= 1'b0;
    else        rd_r <= cmd.exec && cmd.action == ACT_READ;
    rd_time_r <= is_time;
    rd_tb_r   <= tb_r[ptr_r[2:0]];
  end

  assign out_read_data = !rd_r ? 8'd0 : rd_time_r ? rd_tb_r : ram_q;

`ifndef SYNTHESIS
  a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
    ptr_r < PW'(REG_SPACE - 1) || ptr_r == PW'(REG_SPACE - 1))
    else $error("pointer out of range");
  a_halt_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.exec && cmd.action == ACT_TICK && tb_r[0][7]) |=> $stable(sec_r))
    else $error("halted tick changed seconds");
  a_sec_range: assert property (@(posedge clk) disable iff (!rst_n) sec_r <= 6'd59)
    else $error("seconds out of range");
`endif

endmodule
`default_nettype wire

// File: hdl/bcd_real_time_clock_registers_unit.sv
// Top level: BCD real-time clock register file.
`default_nettype none
// Each item is accepted when start is high and busy low; busy then stays high
// for one cycle while the datapath executes. The result byte appears in the
// cycle after that, with out_valid for one cycle; the receiver cannot stall
// it. User RAM powers up undefined; read it only after writing it.
module bcd_real_time_clock_registers_unit
  import brtc_pkg::*;
#(
  parameter int REG_SPACE = 64
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  output logic            busy,
  input  wire logic [1:0] in_action,
  input  wire logic [7:0] in_data_byte,
  output logic            out_valid,
  output logic [7:0]      out_read_data
);

  brtc_cmd_t cmd;

  brtc_ctrl u_ctrl (
    .clk, .rst_n, .start, .in_action, .in_data_byte,
    .busy, .cmd, .out_valid
  );

  brtc_dp #(.REG_SPACE(REG_SPACE)) u_dp (
    .clk, .rst_n, .cmd, .out_read_data
  );

endmodule
`default_nettype wire
